// File: hw/rtl/sleep_timer_heap_queue_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sleep timer heap queue
// Concurrent property wrappers, compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef SLEEP_TIMER_HEAP_QUEUE_ASSERT_SVH
`define SLEEP_TIMER_HEAP_QUEUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define STHQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("lbl");
`define STHQ_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("lbl");
`else
`define STHQ_ASSERT(lbl, clk, rst_n, prop)
`define STHQ_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// File: hw/rtl/sthq_pkg.sv
// ---------------------------------------------------------------------------
// sthq_pkg
// Shared widths, codes and types of the sleep timer heap queue.
// ---------------------------------------------------------------------------
package sthq_pkg;
  localparam int Capacity  = 64;
  localparam int AddrW     = $clog2(Capacity);
  localparam int SizeW     = $clog2(Capacity + 1);
  localparam int MaxResults = 64;
  localparam int CntW      = $clog2(MaxResults + 1);
  localparam int WakeW     = 32;
  localparam int TagW      = 8;
  localparam int RateW     = 10;
  localparam logic [RateW-1:0] RateReset = RateW'(10);

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StNeg  = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  typedef struct packed {
    logic [WakeW-1:0] wake;
    logic [TagW-1:0]  tag;
  } entry_t;

  // Memory access bundle from sequencer to heap memory
  typedef struct packed {
    logic             re;
    logic [AddrW-1:0] raddr;
    logic             we;
    logic [AddrW-1:0] waddr;
    entry_t           wdata;
  } mem_req_t;
endpackage

// File: hw/rtl/sthq_ram.sv
// ---------------------------------------------------------------------------
// sthq_ram
// Single-write, single-read heap storage with registered read data.
// ---------------------------------------------------------------------------
module sthq_ram (
  input  logic              clk_i,
  input  sthq_pkg::mem_req_t req_i,
  output sthq_pkg::entry_t  rdata_o
);
  import sthq_pkg::*;
  entry_t mem [Capacity];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem[req_i.waddr] <= req_i.wdata;
    if (req_i.re) rdata_q <= mem[req_i.raddr];
  end
  assign rdata_o = rdata_q;
endmodule

// File: hw/rtl/sleep_timer_heap_queue.sv
// ---------------------------------------------------------------------------
// sleep_timer_heap_queue
// Timer queue held as a binary min-heap of wake times and tags in one RAM.
// ---------------------------------------------------------------------------
// Channel | Dir | Signals                         | Content
// s_axis  | in  | tvalid tready tdata[23:0]       | sleep_seconds, wake_tag
//         |     | tuser[0]                        | action
// m_axis  | out | tvalid tready tdata[7:0] tlast  | woken_tag
//         |     | tuser[2:0]                      | result_kind, status
// cfg     | in  | cfg_we_i cfg_wdata_i[9:0]       | ticks_per_second
//
// A negative or full sleep request is answered on acceptance. An accepted
// sleep runs a multiply and a wake-sum state, then sift-up as a read and a
// compare state per compare, one compare per level moved plus the final
// one. A tick reads and checks the root, then per woken entry fetches the
// last entry, runs each sift-down step, the final one included, as read,
// left, right and compare states, and reads and checks the new root. All
// of it is bound by the one RAM read port. Results wait in an output
// register; the sequencer holds while it is full. Reset clears the size
// and tick count and sets the rate to 10; heap storage is not cleared.
// ---------------------------------------------------------------------------
`include "sleep_timer_heap_queue_assert.svh"
module sleep_timer_heap_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] sleep_seconds, [23:16] wake_tag
  input  logic        s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] woken_tag
  output logic [2:0]  m_axis_tuser,   // [0] result_kind, [2:1] status
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i
);
  import sthq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_INS, S_UPRD, S_UPCMP,
    S_TRD, S_TCHK, S_POPLRD, S_POPL, S_DNRD, S_DNL, S_DNR, S_DNCMP
  } state_e;

  state_e            state_q;
  logic [RateW-1:0]  rate_q;
  logic [WakeW-1:0]  tick_q;
  logic [SizeW-1:0]  size_q;
  logic [CntW-1:0]   nres_q;
  logic [15:0]       secs_q;
  logic [TagW-1:0]   tag_q;
  logic [25:0]       prod_q;
  entry_t            cur_q;        // entry being sifted
  entry_t            best_q;
  logic [AddrW-1:0]  idx_q;
  logic [AddrW-1:0]  bidx_q;
  logic              hasl_q;
  // output register
  logic              ov_q;
  logic              okind_q;
  logic [1:0]        ostat_q;
  logic [TagW-1:0]   otag_q;
  logic              olast_q;
  // peeked root during tick
  entry_t            root_q;
  // tag of the latest popped entry, not yet sent
  logic [TagW-1:0]   ptag_q;

  mem_req_t req;
  entry_t   rdata;

  sthq_ram u_ram (.clk_i(clk_i), .req_i(req), .rdata_o(rdata));

  logic out_free;
  assign out_free = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;

  logic [AddrW-1:0] parent;
  assign parent = AddrW'((idx_q - AddrW'(1)) >> 1);
  logic [SizeW:0] lchild, rchild;
  assign lchild = {1'b0, idx_q, 1'b1};
  assign rchild = lchild + (SizeW+1)'(1);

  logic [WakeW:0] wsum;
  assign wsum = {1'b0, tick_q} + {7'd0, prod_q};

  always_comb begin
    req = '0;
    unique case (state_q)
      S_UPRD:   begin req.re = 1'b1; req.raddr = parent; end
      S_TRD:    begin req.re = 1'b1; req.raddr = '0; end
      S_POPLRD: begin req.re = 1'b1; req.raddr = AddrW'(size_q - SizeW'(1)); end
      S_DNRD:   begin req.re = 1'b1; req.raddr = AddrW'(lchild); end
      S_DNL:    begin req.re = 1'b1; req.raddr = AddrW'(rchild); end
      S_UPCMP: begin
        req.we = 1'b1;
        if (idx_q != '0 && rdata.wake > cur_q.wake) begin
          req.waddr = idx_q; req.wdata = rdata;
        end else begin
          req.waddr = idx_q; req.wdata = cur_q;
        end
      end
      S_DNCMP: begin
        req.we = 1'b1; req.waddr = idx_q;
        req.wdata = (bidx_q == idx_q) ? cur_q : best_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rate_q  <= RateReset;
      tick_q  <= '0;
      size_q  <= '0;
      ov_q    <= 1'b0;
      nres_q  <= '0;
    end else begin
      if (cfg_we_i) rate_q <= cfg_wdata_i;
      if (ov_q && m_axis_tready) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          secs_q <= s_axis_tdata[15:0];
          tag_q  <= s_axis_tdata[23:16];
          if (s_axis_tuser) begin
            if (tick_q != '1) tick_q <= tick_q + 1'b1;
            nres_q <= '0;
            state_q <= S_TRD;
          end else if (s_axis_tdata[15]) begin
            ov_q <= 1'b1; okind_q <= 1'b0; ostat_q <= StNeg;
            otag_q <= '0; olast_q <= 1'b1;
          end else if (size_q == SizeW'(Capacity)) begin
            ov_q <= 1'b1; okind_q <= 1'b0; ostat_q <= StFull;
            otag_q <= '0; olast_q <= 1'b1;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= secs_q * rate_q;
          state_q <= S_INS;
        end
        S_INS: begin
          cur_q.wake <= wsum[WakeW] ? '1 : wsum[WakeW-1:0];
          cur_q.tag  <= tag_q;
          idx_q      <= AddrW'(size_q);
          state_q    <= S_UPRD;
        end
        S_UPRD: state_q <= S_UPCMP;
        S_UPCMP: begin
          if (idx_q != '0 && rdata.wake > cur_q.wake) begin
            idx_q <= parent; state_q <= S_UPRD;
          end else if (out_free) begin
            size_q <= size_q + 1'b1;
            ov_q <= 1'b1; okind_q <= 1'b0; ostat_q <= StOk;
            otag_q <= '0; olast_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_UPRD; // retry; rewrite is idempotent
          end
        end
        S_TRD: state_q <= S_TCHK;
        S_TCHK: begin
          root_q <= rdata;
          if (size_q != '0 && rdata.wake <= tick_q && nres_q != CntW'(MaxResults)) begin
            state_q <= S_POPLRD;
          end else if (nres_q == '0) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            // release the pending wake as the final one
            ov_q <= 1'b1; okind_q <= 1'b1; ostat_q <= StOk;
            otag_q <= ptag_q; olast_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_POPLRD: state_q <= S_POPL;
        S_POPL: if (out_free) begin
          if (nres_q != '0) begin
            ov_q <= 1'b1; okind_q <= 1'b1; ostat_q <= StOk;
            otag_q <= ptag_q; olast_q <= 1'b0;
          end
          ptag_q <= root_q.tag;
          nres_q <= nres_q + 1'b1;
          cur_q  <= rdata;
          idx_q  <= '0;
          size_q <= size_q - 1'b1;
          state_q <= S_DNRD;
        end
        S_DNRD: begin
          hasl_q <= lchild < {1'b0, size_q};
          bidx_q <= idx_q;
          state_q <= S_DNL;
        end
        S_DNL: begin
          if (hasl_q && rdata.wake < cur_q.wake) begin
            best_q <= rdata; bidx_q <= AddrW'(lchild);
          end else begin
            best_q <= cur_q;
          end
          state_q <= S_DNR;
        end
        S_DNR: begin
          if (rchild < {1'b0, size_q} && rdata.wake < best_q.wake) begin
            best_q <= rdata; bidx_q <= AddrW'(rchild);
          end
          state_q <= S_DNCMP;
        end
        S_DNCMP: begin
          if (bidx_q == idx_q) state_q <= S_TRD;
          else begin
            idx_q <= bidx_q; state_q <= S_DNRD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Each popped tag waits in ptag_q until the next pop or the end of the
  // tick is known, so its last flag is right.
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = otag_q;
  assign m_axis_tuser  = {ostat_q, okind_q};
  assign m_axis_tlast  = olast_q;

  `STHQ_ASSERT(a_size_cap, clk_i, rst_ni, size_q <= SizeW'(Capacity))
  `STHQ_ASSERT(a_hold_out, clk_i, rst_ni,
    (ov_q && !m_axis_tready) |=> (ov_q && $stable(otag_q)))
  `STHQ_ASSERT(a_idle_ready, clk_i, rst_ni,
    (state_q != S_IDLE) |-> !s_axis_tready)
endmodule
